// ===== sv/kfi_pkg.sv =====
// ----------------------------------------------------------------------------
// kfi_pkg: shared types and constants
// Request and result structs, status codes and limits of the key interpolator.
// ----------------------------------------------------------------------------
package kfi_pkg;

  localparam int MAX_KEYS_DEF = 64;
  localparam int KEY_IDX_W    = 6;
  localparam int KEY_COUNT_W  = 7;
  localparam logic signed [32:0] MIN_DELTA = 33'sd7;
  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

  typedef enum logic [0:0] {
    REQ_LOAD  = 1'b0,
    REQ_QUERY = 1'b1
  } req_type_t;

  typedef enum logic [1:0] {
    ST_INTERP = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_SINGLE = 2'd2,
    ST_ZERO   = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    CFG_KEY_COUNT  = 1'b0,
    CFG_TRACK_KIND = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic                 req_type;
    logic [5:0]           key_index;
    logic signed [31:0]   key_time;
    logic signed [31:0]   value_x;
    logic signed [31:0]   value_y;
    logic signed [31:0]   value_z;
    logic signed [31:0]   query_time;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0]   out_x;
    logic signed [31:0]   out_y;
    logic signed [31:0]   out_z;
    logic [5:0]           segment_index;
    logic [1:0]           status;
  } out_res_t;

  // divider handshake
  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [32:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [16:0] quot;
  } div_rsp_t;

endpackage

// ===== sv/kfi_div.sv =====
// ----------------------------------------------------------------------------
// kfi_div: factor divider
// Restoring division, one quotient bit per cycle: floor(num*65536/den), num<den.
// ----------------------------------------------------------------------------
module kfi_div (
  input  logic              clk,
  input  logic              rst_n,
  input  kfi_pkg::div_req_t req,
  output kfi_pkg::div_rsp_t rsp
);
  import kfi_pkg::*;

  logic [33:0] rem_r, rem_nxt;
  logic [32:0] den_r, den_nxt;
  logic [15:0] q_r, q_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [33:0] sh;

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sh       = {rem_r[32:0], 1'b0};
    if (req.start) begin
      rem_nxt  = {2'b00, req.num};
      den_nxt  = req.den;
      cnt_nxt  = 5'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {1'b0, den_r}) begin
        rem_nxt = sh - {1'b0, den_r};
        q_nxt   = {q_r[14:0], 1'b1};
      end else begin
        rem_nxt = sh;
        q_nxt   = {q_r[14:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd15) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = {1'b0, q_r};
endmodule

// ===== sv/kfi_keymem.sv =====
// ----------------------------------------------------------------------------
// kfi_keymem: key store
// Time and value memories, one write port, one registered read port.
// ----------------------------------------------------------------------------
module kfi_keymem #(
  parameter int MAX_KEYS = kfi_pkg::MAX_KEYS_DEF,
  parameter int AW       = $clog2(MAX_KEYS)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic signed [31:0] wtime,
  input  logic [95:0]        wval,
  input  logic [AW-1:0]      raddr,
  output logic signed [31:0] rtime,
  output logic [95:0]        rval
);
  import kfi_pkg::*;

  logic [31:0] time_mem [MAX_KEYS];
  logic [95:0] val_mem  [MAX_KEYS];

  always_ff @(posedge clk) begin
    if (we) begin
      time_mem[waddr] <= wtime;
      val_mem[waddr]  <= wval;
    end
    rtime <= time_mem[raddr];
    rval  <= val_mem[raddr];
  end
endmodule

// ===== sv/keyframe_vec3_interpolator_top.sv =====
// ----------------------------------------------------------------------------
// keyframe_vec3_interpolator_top: keyframe track linear interpolator
// A load writes the key memory as it is taken; the time a query takes is set by
//   the search reads of the key memory and the 16-step divider.
// Throughput: one request at a time; next request taken once the result is
//   handed to the output register. Reset clears control state and the config
//   registers; key memory is undefined until loaded.
// ----------------------------------------------------------------------------
module keyframe_vec3_interpolator_top #(
  parameter int MAX_KEYS = kfi_pkg::MAX_KEYS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  kfi_pkg::in_req_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output kfi_pkg::out_res_t out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [0:0]       cfg_index,
  input  logic [31:0]      cfg_data
);
  import kfi_pkg::*;

  localparam int AW = $clog2(MAX_KEYS);
  localparam int NW = AW + 1;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SRCH  = 9'b000000010,
    S_SWAIT = 9'b000000100,
    S_RD0   = 9'b000001000,
    S_RD1   = 9'b000010000,
    S_CALC  = 9'b000100000,
    S_DIV   = 9'b001000000,
    S_MUL   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [KEY_COUNT_W-1:0] key_count_r;
  logic                   track_kind_r;
  logic [NW-1:0]          n_r, n_nxt, first_r, first_nxt, len_r, len_nxt, half_r, half_nxt;
  logic [NW-1:0]          n_w, seg_w;
  logic signed [31:0]     q_r, q_nxt, t0_r, t0_nxt;
  logic [95:0]            v0_r, v0_nxt;
  logic [AW-1:0]          seg_r, seg_nxt, raddr;
  logic signed [32:0]     delta_w, num_w;
  logic [16:0]            fac_r, fac_nxt;
  logic [1:0]             mcnt_r, mcnt_nxt;
  logic signed [31:0]     res_r [3];
  logic signed [31:0]     res_nxt [3];
  logic                   outv_r, outv_nxt;
  out_res_t               od_r, od_nxt;
  out_res_t               outd_r, outd_nxt;
  logic signed [31:0]     rtime;
  logic [95:0]            rval;
  logic                   we;
  div_req_t               dreq;
  div_rsp_t               drsp;
  logic signed [32:0]     dv_w;
  logic signed [50:0]     prod_w;
  logic signed [31:0]     v0c, v1c;

  assign cfg_ready = 1'b1;
  // result waits in its own register, so a new request can start meanwhile
  assign in_ready  = (state_r == S_IDLE);
  assign we = in_valid && in_ready && (in_data.req_type == REQ_LOAD) &&
              (32'(in_data.key_index) < 32'(MAX_KEYS));

  assign n_w = (32'(key_count_r) > 32'(MAX_KEYS)) ? NW'(MAX_KEYS) : NW'(key_count_r);
  // clamp of first-1 to n-2
  assign seg_w = ((first_r - 1'b1) > (n_r - NW'(2))) ? (n_r - NW'(2)) : (first_r - 1'b1);

  always_comb begin
    unique case (state_r)
      S_RD0:   raddr = AW'(seg_w);
      // key seg+1 stays on the read port through the multiply
      S_RD1, S_CALC, S_DIV, S_MUL: raddr = seg_r + 1'b1;
      default: raddr = AW'(first_r + (len_r >> 1));
    endcase
  end

  kfi_keymem #(.MAX_KEYS(MAX_KEYS), .AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(AW'(in_data.key_index)), .wtime(in_data.key_time),
    .wval({in_data.value_x, in_data.value_y, in_data.value_z}),
    .raddr(raddr), .rtime(rtime), .rval(rval)
  );

  kfi_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign num_w   = 33'(q_r) - 33'(t0_r);
  assign delta_w = 33'(rtime) - 33'(t0_r);

  // one component per cycle in the multiply step
  always_comb begin
    unique case (mcnt_r)
      2'd0:    begin v0c = v0_r[95:64]; v1c = rval[95:64]; end
      2'd1:    begin v0c = v0_r[63:32]; v1c = rval[63:32]; end
      default: begin v0c = v0_r[31:0];  v1c = rval[31:0];  end
    endcase
    dv_w   = 33'(v1c) - 33'(v0c);
    prod_w = 51'(dv_w) * $signed({1'b0, fac_r});
  end

  always_comb begin
    state_nxt = state_r;
    n_nxt = n_r; first_nxt = first_r; len_nxt = len_r; half_nxt = half_r;
    q_nxt = q_r; t0_nxt = t0_r; v0_nxt = v0_r; seg_nxt = seg_r;
    fac_nxt = fac_r; mcnt_nxt = mcnt_r;
    res_nxt = res_r; outv_nxt = outv_r; od_nxt = od_r; outd_nxt = outd_r;
    dreq = '0;
    if (outv_r && out_ready) outv_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready && in_data.req_type == REQ_QUERY) begin
          q_nxt = in_data.query_time;
          n_nxt = n_w;
          first_nxt = NW'(1);
          len_nxt = n_w - 1'b1;
          if (n_w == '0) begin
            od_nxt.out_x = track_kind_r ? ONE_Q16 : '0;
            od_nxt.out_y = track_kind_r ? ONE_Q16 : '0;
            od_nxt.out_z = track_kind_r ? ONE_Q16 : '0;
            od_nxt.segment_index = '0;
            od_nxt.status = ST_EMPTY;
            state_nxt = S_OUT;
          end else if (n_w == NW'(1)) begin
            first_nxt = NW'(1); // seg = 0, read key 0
            state_nxt = S_RD0;
          end else begin
            state_nxt = S_SRCH;
          end
        end
      end
      S_SRCH: begin
        if (len_r == '0) begin
          state_nxt = S_RD0;
        end else begin
          half_nxt = len_r >> 1;
          state_nxt = S_SWAIT;
        end
      end
      S_SWAIT: begin
        if (!(q_r < rtime)) begin
          first_nxt = first_r + half_r + 1'b1;
          len_nxt = len_r - half_r - 1'b1;
        end else begin
          len_nxt = half_r;
        end
        state_nxt = S_SRCH;
      end
      S_RD0: begin
        seg_nxt = (n_r == NW'(1)) ? '0 : AW'(seg_w);
        state_nxt = S_RD1;
      end
      S_RD1: begin
        t0_nxt = rtime;
        v0_nxt = rval;
        if (n_r == NW'(1)) begin
          od_nxt = {rval, 6'd0, ST_SINGLE};
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        if (delta_w > -MIN_DELTA && delta_w < MIN_DELTA) begin
          od_nxt = {v0_r, 6'(seg_r), ST_ZERO};
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_DIV;
          mcnt_nxt = 2'd0;
          if (num_w == '0 || (num_w[32] != delta_w[32])) begin
            fac_nxt = '0;
            state_nxt = S_MUL;
          end else begin
            dreq.num = num_w[32] ? 32'(-num_w) : num_w[31:0];
            dreq.den = delta_w[32] ? 33'(-delta_w) : delta_w;
            if ({1'b0, dreq.num} >= dreq.den) begin
              fac_nxt = 17'h10000;
              state_nxt = S_MUL;
            end else begin
              dreq.start = 1'b1;
            end
          end
        end
      end
      S_DIV: begin
        if (drsp.done) begin
          fac_nxt = drsp.quot;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        // rval still holds key seg+1 (read address unchanged)
        res_nxt[mcnt_r] = v0c + 32'(prod_w >>> 16);
        mcnt_nxt = mcnt_r + 2'd1;
        if (mcnt_r == 2'd2) begin
          od_nxt = {res_nxt[0], res_nxt[1], res_nxt[2], 6'(seg_r), ST_INTERP};
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // hand over once the output register is free or being emptied
        if (!outv_r || out_ready) begin
          outd_nxt = od_r;
          outv_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      outv_r <= 1'b0;
      key_count_r <= '0;
      track_kind_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      outv_r <= outv_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_KEY_COUNT:  key_count_r  <= cfg_data[KEY_COUNT_W-1:0];
          CFG_TRACK_KIND: track_kind_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
    n_r <= n_nxt; first_r <= first_nxt; len_r <= len_nxt; half_r <= half_nxt;
    q_r <= q_nxt; t0_r <= t0_nxt; v0_r <= v0_nxt; seg_r <= seg_nxt;
    fac_r <= fac_nxt; mcnt_r <= mcnt_nxt;
    res_r <= res_nxt; od_r <= od_nxt; outd_r <= outd_nxt;
  end

  assign out_valid = outv_r;
  assign out_data  = outd_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready) else $error("request taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result dropped");
  a_factor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> (fac_r <= 17'h10000)) else $error("factor out of range");
endmodule
